[sv/v3n_pkg.sv]
`timescale 1ns / 1ps

package v3n_pkg;

	localparam int COMP_W = 16;
	localparam int NCOMP  = 3;

	localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
	localparam logic [30:0] Y_MAX     = 31'h7FFF_FFFF;

	// Per-item context that rides along the pipeline
	typedef struct packed {
		logic [NCOMP-1:0][COMP_W-1:0] comp;
		logic [31:0]                  sum;
		logic [31:0]                  m;
		logic [3:0]                   hs;
		logic                         zero;
	} ctx_t;

	// Elaboration-time integer square root for the seed table
	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		v    = val;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

endpackage

[sv/vector3_normalize.sv]
`timescale 1ns / 1ps

// Throughput: one vector per cycle unless the output stalls; each Newton step is four
// register stages (square, scale by mantissa, subtract, rescale), every multiply
// registered.
// A stage moves when it is empty or the stage after it moves, so bubbles close up.
// Reset (arst_n low, asynchronous) empties the pipeline; data registers are not cleared.
module vector3_normalize #(
	parameter int NEWTON_STEPS    = 3,
	parameter int SEED_TABLE_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // comp_x[15:0], comp_y[31:16], comp_z[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // unit_x[15:0], unit_y[31:16], unit_z[47:32], magnitude[63:48]
	output logic        m_tuser   // zero_vector
);

	localparam int NSTG  = 6 + 4 * NEWTON_STEPS;
	localparam int ST_F1 = NSTG - 1;
	localparam int ST_F2 = NSTG;
	localparam int NSEED = 2 ** SEED_TABLE_BITS;

	logic [NSTG:1]   v_q;
	logic [NSTG:1]   vin;
	logic [NSTG+1:1] en;

	assign vin = {v_q[NSTG-1:1], s_tvalid};

	always_comb begin
		en[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en[k]) v_q[k] <= vin[k];
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[NSTG];

	// Seed table: 1/sqrt of each bin midpoint, truncated to Q2.16, held in Q1.30
	logic [30:0] seed_rom [NSEED];

	for (genvar i = 0; i < NSEED; i++) begin : g_seed
		localparam logic [63:0] QUO  = (64'd1 << (33 + SEED_TABLE_BITS)) / (2 * i + 1);
		localparam logic [63:0] ROOT = v3n_pkg::isqrt64(QUO) << 14;
		assign seed_rom[i] = (ROOT > 64'(v3n_pkg::Y_MAX)) ? v3n_pkg::Y_MAX : ROOT[30:0];
	end

	// Stage 1: squares
	logic [v3n_pkg::NCOMP-1:0][15:0] comp_s1;
	logic [v3n_pkg::NCOMP-1:0][30:0] sq_s1;
	logic [v3n_pkg::NCOMP-1:0][31:0] sq_full;

	always_comb begin
		for (int c = 0; c < v3n_pkg::NCOMP; c++) begin
			sq_full[c] = 32'($signed(s_tdata[16*c +: 16])) * 32'($signed(s_tdata[16*c +: 16]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int c = 0; c < v3n_pkg::NCOMP; c++) begin
				comp_s1[c] <= s_tdata[16*c +: 16];
				sq_s1[c]   <= sq_full[c][30:0];
			end
		end
	end

	// Stage 2: sum of squares
	logic [v3n_pkg::NCOMP-1:0][15:0] comp_s2;
	logic [31:0]                     sum_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			comp_s2 <= comp_s1;
			sum_s2  <= 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
		end
	end

	// Stage 3: even normalizing shift
	logic [4:0]  msb;
	logic [3:0]  hs;
	v3n_pkg::ctx_t ctx_s3;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (sum_s2[i]) msb = 5'(i);
		end
		hs = 4'((5'd31 - msb) >> 1);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ctx_s3.comp <= comp_s2;
			ctx_s3.sum  <= sum_s2;
			ctx_s3.m    <= sum_s2 << {hs, 1'b0};
			ctx_s3.hs   <= hs;
			ctx_s3.zero <= (sum_s2 == '0);
		end
	end

	// Stage 4: seed lookup
	v3n_pkg::ctx_t ctx_s4;
	logic [30:0]   seed_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ctx_s4  <= ctx_s3;
			seed_s4 <= seed_rom[ctx_s3.m[31 -: SEED_TABLE_BITS]];
		end
	end

	logic [30:0]   y_ch   [0:NEWTON_STEPS];
	v3n_pkg::ctx_t ctx_ch [0:NEWTON_STEPS];

	assign y_ch[0]   = seed_s4;
	assign ctx_ch[0] = ctx_s4;

	for (genvar j = 0; j < NEWTON_STEPS; j++) begin : g_newton
		localparam int SA = 5 + 4 * j;
		localparam int SB = SA + 1;
		localparam int SC = SA + 2;
		localparam int SD = SA + 3;

		v3n_pkg::ctx_t ctx_sa, ctx_sb, ctx_sc, ctx_sd;
		logic [30:0]   y_sa, y_sb, y_sc, y_sd;
		logic [31:0]   y2_sa, t_sb, d_sc;
		logic [61:0]   p_yy;
		logic [63:0]   p_my;
		logic [62:0]   p_yd;

		assign p_yy = 62'(y_ch[j]) * 62'(y_ch[j]);
		assign p_my = 64'(ctx_sa.m) * 64'(y2_sa);
		assign p_yd = 63'(y_sc) * 63'(d_sc);

		always_ff @(posedge clk) begin
			if (en[SA]) begin
				ctx_sa <= ctx_ch[j];
				y_sa   <= y_ch[j];
				y2_sa  <= p_yy[61:30];
			end
			if (en[SB]) begin
				ctx_sb <= ctx_sa;
				y_sb   <= y_sa;
				t_sb   <= p_my[63:32];
			end
			if (en[SC]) begin
				ctx_sc <= ctx_sb;
				y_sc   <= y_sb;
				d_sc   <= (t_sb > v3n_pkg::THREE_Q30) ? '0 : v3n_pkg::THREE_Q30 - t_sb;
			end
			if (en[SD]) begin
				ctx_sd <= ctx_sc;
				y_sd   <= p_yd[62] ? v3n_pkg::Y_MAX : p_yd[61:31];
			end
		end

		assign y_ch[j+1]   = y_sd;
		assign ctx_ch[j+1] = ctx_sd;
	end

	// Final stage 1: scale components and sum by the reciprocal root
	v3n_pkg::ctx_t                   ctx_f1;
	logic [v3n_pkg::NCOMP-1:0][46:0] pc_f1;
	logic [62:0]                     pl_f1;
	logic [v3n_pkg::NCOMP-1:0][15:0] cmag;

	always_comb begin
		for (int c = 0; c < v3n_pkg::NCOMP; c++) begin
			cmag[c] = ctx_ch[NEWTON_STEPS].comp[c][15]
				? 16'(-ctx_ch[NEWTON_STEPS].comp[c]) : ctx_ch[NEWTON_STEPS].comp[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_F1]) begin
			ctx_f1 <= ctx_ch[NEWTON_STEPS];
			for (int c = 0; c < v3n_pkg::NCOMP; c++) begin
				pc_f1[c] <= 47'(cmag[c]) * 47'(y_ch[NEWTON_STEPS]);
			end
			pl_f1 <= 63'(ctx_ch[NEWTON_STEPS].sum) * 63'(y_ch[NEWTON_STEPS]);
		end
	end

	// Final stage 2: round, restore sign, saturate; a zero vector passes its components through
	logic [5:0]                      shu, shl;
	logic [v3n_pkg::NCOMP-1:0][47:0] ru;
	logic [v3n_pkg::NCOMP-1:0][15:0] unit;
	logic [63:0]                     rl;
	logic [15:0]                     len;

	always_comb begin
		shu = 6'd32 - 6'(ctx_f1.hs);
		shl = 6'd46 - 6'(ctx_f1.hs);
		for (int c = 0; c < v3n_pkg::NCOMP; c++) begin
			ru[c] = ({1'b0, pc_f1[c]} + (48'd1 << (shu - 6'd1))) >> shu;
			if (ctx_f1.comp[c][15]) begin
				unit[c] = (ru[c] > 48'd32768) ? 16'h8000 : 16'(-ru[c][15:0]);
			end else begin
				unit[c] = (ru[c] > 48'd32767) ? 16'h7FFF : ru[c][15:0];
			end
		end
		rl  = ({1'b0, pl_f1} + (64'd1 << (shl - 6'd1))) >> shl;
		len = (rl > 64'd65535) ? 16'hFFFF : rl[15:0];
	end

	logic [63:0] data_f2;
	logic        zero_f2;

	always_ff @(posedge clk) begin
		if (en[ST_F2]) begin
			if (ctx_f1.zero) begin
				data_f2 <= {16'd0, ctx_f1.comp[2], ctx_f1.comp[1], ctx_f1.comp[0]};
			end else begin
				data_f2 <= {len, unit[2], unit[1], unit[0]};
			end
			zero_f2 <= ctx_f1.zero;
		end
	end

	assign m_tdata = data_f2;
	assign m_tuser = zero_f2;

	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is being drained");

	a_ready_when_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[63:48] == 16'd0))
		else $error("zero vector reported with nonzero length");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int STEPS     = 3;
	localparam int ROM_BITS  = 6;
	localparam int LATENCY   = 6 + 4 * STEPS;
	localparam int WD_LIMIT  = 5000;
	localparam int N_RANDOM  = 450;

	typedef struct packed {
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic [15:0] mag;
		logic        zero;
	} unit_res_t;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		bit          typed;
		unit_res_t   res;
	} vec_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;

	unit_res_t   pending_q[$];
	int          err_cnt;
	int          idle_cycles;
	bit          hold_off;
	bit          calm;

	vector3_normalize #(.NEWTON_STEPS(STEPS), .SEED_TABLE_BITS(ROM_BITS)) dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = '0;
		b = 64'd1 << 62;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] scale_comp(input logic signed [15:0] c,
			input logic [63:0] y, input int sh);
		logic [63:0] a;
		logic [63:0] r;
		longint      v;
		a = (c < 0) ? 64'(-longint'(c)) : 64'(c);
		r = (a * y + (64'd1 << (sh - 1))) >> sh;
		v = (c < 0) ? -longint'(r) : longint'(r);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic unit_res_t normalize(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		unit_res_t   o;
		logic [63:0] sum;
		logic [63:0] m;
		logic [63:0] est;
		logic [63:0] y2;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] len;
		int          s;
		int          p;
		sum = 64'(longint'($signed(x)) * $signed(x)) + 64'(longint'($signed(y)) * $signed(y))
			+ 64'(longint'($signed(z)) * $signed(z));
		if (sum == 0) begin
			o = '{x, y, z, 16'd0, 1'b1};
			return o;
		end
		p = 0;
		while (p < 31 && (sum >> (p + 1)) != 0)
			p++;
		s = (31 - p) & ~1;
		m = (sum << s) & 64'hFFFF_FFFF;
		est = m >> (32 - ROM_BITS);
		est = int_sqrt((64'd1 << (33 + ROM_BITS)) / (2 * est + 1)) << 14;
		if (est > 64'h7FFF_FFFF)
			est = 64'h7FFF_FFFF;
		for (int k = 0; k < STEPS; k++) begin
			y2 = (est * est) >> 30;
			t = (m * y2) >> 32;
			d = (t > 64'hC000_0000) ? 64'd0 : 64'hC000_0000 - t;
			est = (est * d) >> 31;
			if (est > 64'h7FFF_FFFF)
				est = 64'h7FFF_FFFF;
		end
		o.ux = scale_comp(x, est, 32 - s / 2);
		o.uy = scale_comp(y, est, 32 - s / 2);
		o.uz = scale_comp(z, est, 32 - s / 2);
		len = (sum * est + (64'd1 << (45 - s / 2))) >> (46 - s / 2);
		o.mag = (len > 65535) ? 16'hFFFF : len[15:0];
		o.zero = 1'b0;
		return o;
	endfunction

	task automatic send_vec(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input bit typed, input unit_res_t res);
		unit_res_t want;
		want = typed ? res : normalize(x, y, z);
		if (!calm) begin
			while ($urandom_range(99) < 28) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tdata <= {z, y, x};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pending_q.push_back(want);
		@(negedge clk);
	endtask

	// Receiver side: random stalls, one long hold-off, and the calm window
	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		unit_res_t exp_res;
		unit_res_t got;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser};
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $realtime, got);
				err_cnt++;
			end else begin
				exp_res = pending_q.pop_front();
				if (got.ux !== exp_res.ux)
					$display("%0t: unit_x exp %h got %h", $realtime, exp_res.ux, got.ux);
				if (got.uy !== exp_res.uy)
					$display("%0t: unit_y exp %h got %h", $realtime, exp_res.uy, got.uy);
				if (got.uz !== exp_res.uz)
					$display("%0t: unit_z exp %h got %h", $realtime, exp_res.uz, got.uz);
				if (got.mag !== exp_res.mag)
					$display("%0t: magnitude exp %h got %h", $realtime, exp_res.mag, got.mag);
				if (got.zero !== exp_res.zero)
					$display("%0t: zero_vector exp %b got %b", $realtime, exp_res.zero,
						got.zero);
				if (got !== exp_res)
					err_cnt++;
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Long receiver hold-off while the sender keeps offering
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (120) @(posedge clk);
		hold_off = 1'b1;
		repeat (80) @(posedge clk);
		hold_off = 1'b0;
	end

	vec_row_t table_rows[$];

	initial begin
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rz;
		int          sh;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		err_cnt = 0;
		idle_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		table_rows = '{
			'{16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 16'h0000, 16'h0, 1'b1}},
			'{16'h0100, 16'h0000, 16'h0000, 0, '0},
			'{16'h0000, 16'hFF00, 16'h0000, 0, '0},
			'{16'h0000, 16'h0000, 16'h0001, 0, '0},
			'{16'h0001, 16'h0001, 16'h0001, 0, '0},
			'{16'hFFFF, 16'h0000, 16'h0000, 0, '0},
			'{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
			'{16'h8000, 16'h8000, 16'h8000, 0, '0},
			'{16'h8000, 16'h0000, 16'h0000, 0, '0},
			'{16'h7FFF, 16'h0000, 16'h8000, 0, '0},
			'{16'h0300, 16'h0400, 16'h0000, 0, '0},
			'{16'hFD00, 16'hFC00, 16'h0C00, 0, '0},
			'{16'h5555, 16'hAAAA, 16'h0F0F, 0, '0},
			'{16'h0000, 16'h0000, 16'h8000, 0, '0}
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (table_rows[i])
			send_vec(table_rows[i].x, table_rows[i].y, table_rows[i].z,
				table_rows[i].typed, table_rows[i].res);
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 200 && n < 260);
			rx = $urandom;
			ry = $urandom;
			rz = $urandom;
			case ($urandom_range(5))
				0: begin
					// small vectors exercise large normalization shifts
					sh = $urandom_range(15, 4);
					rx = $signed(rx) >>> sh;
					ry = $signed(ry) >>> sh;
					rz = $signed(rz) >>> sh;
				end
				1: begin
					rx = ($urandom_range(1)) ? rx : 16'h0;
					ry = ($urandom_range(1)) ? 16'h0 : ry;
				end
				2: if ($urandom_range(7) == 0) begin
					rx = 16'h0;
					ry = 16'h0;
					rz = 16'h0;
				end
				default: ;
			endcase
			send_vec(rx, ry, rz, 0, '0);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;
		wait (pending_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (err_cnt == 0 && pending_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

[sim.f]
sv/v3n_pkg.sv
sv/vector3_normalize.sv
dv/tb_top.sv
